// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;
  localparam int DEPTH_MAX = 32;
  // wide enough to hold a count of DEPTH_MAX
  localparam int CNT_W     = $clog2(DEPTH_MAX + 1);

  typedef enum logic [1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_DELETE    = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH_HEAD,
    CMD_PUSH_TAIL,
    CMD_DELETE,
    CMD_ROT_LEFT,
    CMD_ROT_RIGHT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_e              kind;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  index;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/deque_with_indexed_delete.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                   Handshake
// request   in         opcode_i, value_i                       start_i && !busy_o
// result    out        direction_o, has_element_o, element_o,  res_valid_o, one cycle
//                      index_error_o, overflow_o, last_o
//
// A request is applied to the cell chain in the cycle it is taken; the chain then
// rotates once per result of a non-empty list, giving 2*count results (2 for an
// empty list), half of them head to tail and then half tail to head.
// Each result is registered and appears on the ports in the cycle after it is formed.
// Reset clears the count, the flags and the control; the cells need no reset.
// The receiver cannot stall; busy_o holds off new requests until the last result is formed.

module deque_with_indexed_delete
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic signed [31:0] value_i,
  output logic                   res_valid_o,
  output logic                   direction_o,
  output logic                   has_element_o,
  output logic signed [31:0]     element_o,
  output logic                   index_error_o,
  output logic                   overflow_o,
  output logic                   last_o
);

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);

  state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  step_q, step_d;
  logic              ierr_q, ierr_d;
  logic              ovf_q, ovf_d;
  logic              vld_q, vld_d;
  logic              dir_q, dir_d;
  logic              has_q, has_d;
  logic              last_q, last_d;
  logic [DATA_W-1:0] elem_q, elem_d;

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] head, tail;
  logic              empty, phase_end, del_ok, full;

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid_p
      assign prev = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid_n
      assign next = cell_data[g+1];
    end
    dq_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (next),
      .data_o (cell_data[g])
    );
  end

  assign head = cell_data[0];

  always_comb begin
    tail = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i) == count_q - 1'b1) tail = cell_data[i];
    end
  end

  assign empty     = (count_q == '0);
  assign phase_end = empty || (step_q == count_q - 1'b1);
  assign full      = (count_q >= DepthCnt);
  // negative or at/after count is out of range
  assign del_ok    = !value_i[31] && (value_i[30:CNT_W] == '0) &&
                     (value_i[CNT_W-1:0] < count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_FWD;
      ST_FWD:  if (phase_end) state_d = ST_BWD;
      ST_BWD:  if (phase_end) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and result forming
  always_comb begin
    cmd       = '{kind: CMD_NONE, count: count_q, index: value_i[CNT_W-1:0],
                  data: value_i};
    count_d   = count_q;
    step_d    = step_q;
    ierr_d    = ierr_q;
    ovf_d     = ovf_q;
    vld_d     = 1'b0;
    dir_d     = 1'b0;
    has_d     = 1'b0;
    last_d    = 1'b0;
    elem_d    = '0;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (start_i) begin
          ierr_d = 1'b0;
          ovf_d  = 1'b0;
          unique case (op_e'(opcode_i))
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                cmd.kind = (op_e'(opcode_i) == OP_PUSH_HEAD) ? CMD_PUSH_HEAD
                                                              : CMD_PUSH_TAIL;
                count_d  = count_q + 1'b1;
              end
            end
            OP_DELETE: begin
              if (del_ok) begin
                cmd.kind = CMD_DELETE;
                count_d  = count_q - 1'b1;
              end else begin
                ierr_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FWD: begin
        vld_d  = 1'b1;
        has_d  = !empty;
        elem_d = empty ? '0 : head;
        step_d = phase_end ? '0 : step_q + 1'b1;
        if (!empty) begin
          cmd.kind = CMD_ROT_LEFT;
          cmd.data = head;
        end
      end
      ST_BWD: begin
        vld_d  = 1'b1;
        dir_d  = 1'b1;
        has_d  = !empty;
        elem_d = empty ? '0 : tail;
        last_d = phase_end;
        step_d = phase_end ? '0 : step_q + 1'b1;
        if (!empty) begin
          cmd.kind = CMD_ROT_RIGHT;
          cmd.data = tail;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      ierr_q  <= 1'b0;
      ovf_q   <= 1'b0;
      vld_q   <= 1'b0;
      dir_q   <= 1'b0;
      has_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      ierr_q  <= ierr_d;
      ovf_q   <= ovf_d;
      vld_q   <= vld_d;
      dir_q   <= dir_d;
      has_q   <= has_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign res_valid_o   = vld_q;
  assign direction_o   = dir_q;
  assign has_element_o = has_q;
  assign element_o     = elem_q;
  assign index_error_o = ierr_q;
  assign overflow_o    = ovf_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ===== src/dq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dq_cell
  import dq_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic              clk_i,
  input  wire cell_cmd_t         cmd_i,
  input  wire logic [DATA_W-1:0] prev_i,
  input  wire logic [DATA_W-1:0] next_i,
  output logic      [DATA_W-1:0] data_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.kind)
      CMD_PUSH_HEAD: data_d = (MyIdx == '0) ? cmd_i.data : prev_i;
      CMD_PUSH_TAIL: if (MyIdx == cmd_i.count) data_d = cmd_i.data;
      CMD_DELETE:    if (MyIdx >= cmd_i.index) data_d = next_i;
      // last occupied cell takes the old head
      CMD_ROT_LEFT:  data_d = (MyIdx == cmd_i.count - 1'b1) ? cmd_i.data : next_i;
      // first cell takes the old tail
      CMD_ROT_RIGHT: data_d = (MyIdx == '0) ? cmd_i.data : prev_i;
      default:       data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== src/dq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        res_valid_o,
  input wire logic        direction_o,
  input wire logic        has_element_o,
  input wire logic [31:0] element_o,
  input wire logic        last_o
);

  // a taken request keeps the block busy while its listing starts
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o low after request taken");

  a_last_is_backward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |-> direction_o)
    else $error("last result not in tail-to-head listing");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !has_element_o) |-> (element_o == '0))
    else $error("empty marker carries nonzero element");

  // results of one request come while busy, except the final one
  a_stream_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy_o)
    else $error("non-final result while idle");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |=> !res_valid_o)
    else $error("result directly after last");

endmodule

bind deque_with_indexed_delete dq_checker u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .res_valid_o   (res_valid_o),
  .direction_o   (direction_o),
  .has_element_o (has_element_o),
  .element_o     (element_o),
  .last_o        (last_o)
);

`default_nettype wire
